>>> hw/rtl/sn4_pkg.sv
// Shared types, constants and the simplex rank table for the 4D noise pipeline.
`timescale 1ns / 1ps

package sn4_pkg;

  // Fixed-point work format: signed Q.28
  localparam int WORK_BITS = 28;

  // Permutation table geometry
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  // Skew factor F4 in Q0.32, unskew factor G4 in Q.28, falloff radius 0.6 in Q.28
  localparam logic signed [32:0] F4_Q32      = 33'sd1327217885;
  localparam logic        [25:0] G4_Q28      = 26'd37096868;
  localparam logic        [27:0] FALLOFF_Q28 = 28'd161061274;

  // Item opcodes
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Control that rides along with every item
  typedef struct packed {
    logic                vld;
    logic                ld;
    logic [PERM_AW-1:0]  pidx;
    logic [7:0]          pval;
  } sn4_ctl_t;

  // Front-end result: cell bytes and corner-zero offsets
  typedef struct packed {
    sn4_ctl_t         ctl;
    logic [3:0][7:0]  cb;
    logic [3:0][31:0] off;
  } sn4_front_t;

  // Comparison code to per-axis rank {r0,r1,r2,r3}; r0 in the top two bits
  function automatic logic [7:0] rank_lookup(input logic [5:0] code);
    logic [7:0] r;
    r = 8'h00;
    unique case (code)
      6'd0:  r = {2'd0, 2'd1, 2'd2, 2'd3};
      6'd1:  r = {2'd0, 2'd1, 2'd3, 2'd2};
      6'd3:  r = {2'd0, 2'd2, 2'd3, 2'd1};
      6'd7:  r = {2'd1, 2'd2, 2'd3, 2'd0};
      6'd8:  r = {2'd0, 2'd2, 2'd1, 2'd3};
      6'd10: r = {2'd0, 2'd3, 2'd1, 2'd2};
      6'd11: r = {2'd0, 2'd3, 2'd2, 2'd1};
      6'd15: r = {2'd1, 2'd3, 2'd2, 2'd0};
      6'd24: r = {2'd1, 2'd2, 2'd0, 2'd3};
      6'd26: r = {2'd1, 2'd3, 2'd0, 2'd2};
      6'd30: r = {2'd2, 2'd3, 2'd0, 2'd1};
      6'd31: r = {2'd2, 2'd3, 2'd1, 2'd0};
      6'd32: r = {2'd1, 2'd0, 2'd2, 2'd3};
      6'd33: r = {2'd1, 2'd0, 2'd3, 2'd2};
      6'd37: r = {2'd2, 2'd0, 2'd3, 2'd1};
      6'd39: r = {2'd2, 2'd1, 2'd3, 2'd0};
      6'd48: r = {2'd2, 2'd0, 2'd1, 2'd3};
      6'd52: r = {2'd3, 2'd0, 2'd1, 2'd2};
      6'd53: r = {2'd3, 2'd0, 2'd2, 2'd1};
      6'd55: r = {2'd3, 2'd1, 2'd2, 2'd0};
      6'd56: r = {2'd2, 2'd1, 2'd0, 2'd3};
      6'd60: r = {2'd3, 2'd1, 2'd0, 2'd2};
      6'd62: r = {2'd3, 2'd2, 2'd0, 2'd1};
      6'd63: r = {2'd3, 2'd2, 2'd1, 2'd0};
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/simplex_noise_4d_top.sv
// Top level of the 4D simplex noise pipeline: ranking, hash lookups, corners, output.
`timescale 1ns / 1ps

// Evaluates 4D simplex noise on one signed Q7.16 point per item (Q(23-F).F for
// FRAC_BITS = F) and returns the value in signed Q1.F, saturated to +/-1.0. An item
// with opcode set writes one byte of the permutation table instead and returns zero;
// all 256 entries must be loaded before the first evaluation. The pipeline takes one
// item every clock when not stalled; out_stall freezes the whole pipeline. Each
// of the four chained hash levels owns five copies of the table (one per corner),
// so a load writes each copy as it passes that level, in item order.
module simplex_noise_4d_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [23:0] in_coord_z,
  input  logic signed [23:0] in_coord_w,
  input  logic [7:0]         in_perm_index,
  input  logic [7:0]         in_perm_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_noise_value
);

  localparam int WB = sn4_pkg::WORK_BITS;
  localparam logic signed [43:0] SAT_HI = 44'sd1 <<< FRAC_BITS;
  localparam logic signed [43:0] SAT_LO = -SAT_HI;

  logic en;
  sn4_pkg::sn4_front_t front;

  sn4_pkg::sn4_ctl_t  ctl_r [7:14];
  logic [3:0][31:0]   off7_r;
  logic [7:0]         cb_r  [7:10][4];
  logic [3:0]         st_r  [7:10][5];
  logic signed [37:0] total14_r;
  logic               out_valid_r;
  logic signed [17:0] noise_r;

  logic [5:0]         code;
  logic [7:0]         rk;
  logic [3:0]         st7   [5];
  logic [7:0]         pv    [4][5];
  logic [7:0]         hin   [4][5];
  logic signed [34:0] contrib [5];
  logic signed [37:0] total;
  logic signed [43:0] scaled;
  logic signed [43:0] sat;

  // whole pipeline advances unless a finished item is held at the output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  sn4_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_opcode     (in_opcode),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_coord_w    (in_coord_w),
    .in_perm_index (in_perm_index),
    .in_perm_value (in_perm_value),
    .front_o       (front)
  );

  // rank the four offsets and derive the corner step pattern
  always_comb begin
    code = {$signed(front.off[0]) > $signed(front.off[1]),
            $signed(front.off[0]) > $signed(front.off[2]),
            $signed(front.off[1]) > $signed(front.off[2]),
            $signed(front.off[0]) > $signed(front.off[3]),
            $signed(front.off[1]) > $signed(front.off[3]),
            $signed(front.off[2]) > $signed(front.off[3])};
    rk = sn4_pkg::rank_lookup(code);
    for (int k = 0; k < 5; k++) begin
      for (int d = 0; d < 4; d++) begin
        st7[k][d] = (k != 0) && ({1'b0, rk[7 - 2*d -: 2]} >= 3'(4 - k));
      end
    end
  end

  // control that rides with each item; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 7; s <= 14; s++) begin
        ctl_r[s].vld <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[7] <= front.ctl;
      for (int s = 8; s <= 14; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      out_valid_r <= ctl_r[14].vld;
    end
  end

  // hash-stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      off7_r <= front.off;
      for (int d = 0; d < 4; d++) begin
        cb_r[7][d] <= front.cb[d];
      end
      for (int k = 0; k < 5; k++) begin
        st_r[7][k] <= st7[k];
      end
      for (int s = 8; s <= 10; s++) begin
        for (int d = 0; d < 4; d++) begin
          cb_r[s][d] <= cb_r[s-1][d];
        end
        for (int k = 0; k < 5; k++) begin
          st_r[s][k] <= st_r[s-1][k];
        end
      end
    end
  end

  // chained permutation lookups: level L hashes axis 3-L at stage 7+L
  genvar gl, gk;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lvl
      for (gk = 0; gk < 5; gk++) begin : g_crn
        if (gl == 0) begin : g_first
          assign hin[gl][gk] = 8'd0;
        end else begin : g_next
          assign hin[gl][gk] = pv[gl-1][gk];
        end

        sn4_perm_mem u_mem (
          .clk     (clk),
          .wr_en   (en && ctl_r[7+gl].vld && (ctl_r[7+gl].ld == sn4_pkg::OP_LOAD)),
          .wr_addr (ctl_r[7+gl].pidx),
          .wr_data (ctl_r[7+gl].pval),
          .rd_en   (en),
          .rd_addr (cb_r[7+gl][3-gl] + 8'(st_r[7+gl][gk][3-gl]) + hin[gl][gk]),
          .rd_data (pv[gl][gk])
        );
      end
    end

    for (gk = 0; gk < 5; gk++) begin : g_corner
      sn4_corner u_corner (
        .clk       (clk),
        .en        (en),
        .off_i     (off7_r),
        .step_i    (st_r[7][gk]),
        .kofs_i    (28'(gk * sn4_pkg::G4_Q28)),
        .grad_i    (pv[3][gk][4:0]),
        .contrib_o (contrib[gk])
      );
    end
  endgenerate

  // sum of corners, then scale by 27 and saturate to +/-1.0
  always_comb begin
    total = '0;
    for (int k = 0; k < 5; k++) begin
      total = total + 38'(contrib[k]);
    end
    scaled = (44'(total14_r) * 44'sd27) >>> (WB - FRAC_BITS);
    if (scaled > SAT_HI) begin
      sat = SAT_HI;
    end else if (scaled < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total14_r <= total;
      noise_r   <= (ctl_r[14].ld == sn4_pkg::OP_LOAD) ? 18'sd0 : sat[17:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise_r;

endmodule

>>> hw/rtl/sn4_perm_mem.sv
// One copy of the 256 x 8 permutation table with a registered read port.
`timescale 1ns / 1ps

module sn4_perm_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [sn4_pkg::PERM_AW-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        rd_en,
  input  logic [sn4_pkg::PERM_AW-1:0] rd_addr,
  output logic [7:0]                  rd_data
);

  logic [7:0] mem [sn4_pkg::PERM_DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/sn4_front.sv
// Front end: input register, skew multiply, cell floor, unskew multiply, offsets.
`timescale 1ns / 1ps

module sn4_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic                in_opcode,
  input  logic signed [23:0]  in_coord_x,
  input  logic signed [23:0]  in_coord_y,
  input  logic signed [23:0]  in_coord_z,
  input  logic signed [23:0]  in_coord_w,
  input  logic [7:0]          in_perm_index,
  input  logic [7:0]          in_perm_value,
  output sn4_pkg::sn4_front_t front_o
);

  localparam int WB  = sn4_pkg::WORK_BITS;
  localparam int PW  = 24 + WB - FRAC_BITS;          // coordinate in Q.28
  localparam int SW  = PW + 2;                       // coordinate plus skew
  localparam int CW  = SW - WB;                      // cell index
  localparam int CSW = CW + 2;                       // sum of four cells
  localparam int UW  = CSW + 27;                     // unskew product
  localparam int XW  = ((SW > UW) ? SW : UW) + 2;    // offset work width
  localparam int CEW = (CW > 8) ? CW : 8;
  localparam int MW  = 26 + 33;                      // skew product

  sn4_pkg::sn4_ctl_t ctl_r [1:6];

  logic signed [23:0]    c1_r    [4];
  logic signed [25:0]    sum1_r;
  logic signed [23:0]    c2_r    [4];
  logic signed [MW-1:0]  prod2_r;
  logic signed [SW-1:0]  ps3_r   [4];
  logic signed [SW-1:0]  skew3_r;
  logic [WB-1:0]         frac4_r [4];
  logic [7:0]            cb4_r   [4];
  logic signed [CSW-1:0] csum4_r;
  logic signed [SW-1:0]  skew4_r;
  logic [WB-1:0]         frac5_r [4];
  logic [7:0]            cb5_r   [4];
  logic signed [UW-1:0]  unsk5_r;
  logic signed [SW-1:0]  skew5_r;
  logic [3:0][7:0]       cb6_r;
  logic [3:0][31:0]      off6_r;

  logic signed [23:0]    cin    [4];
  logic signed [SW-1:0]  skew2;
  logic signed [CW-1:0]  cell3  [4];
  logic signed [CEW-1:0] cellx3 [4];
  logic signed [CSW-1:0] csum3;

  assign cin[0] = in_coord_x;
  assign cin[1] = in_coord_y;
  assign cin[2] = in_coord_z;
  assign cin[3] = in_coord_w;

  // skew = sum * F4 in Q.28, cell = floor(coord + skew)
  always_comb begin
    skew2 = SW'(prod2_r >>> (FRAC_BITS + 4));
    csum3 = '0;
    for (int d = 0; d < 4; d++) begin
      cell3[d]  = ps3_r[d][SW-1:WB];
      cellx3[d] = CEW'(cell3[d]);
      csum3     = csum3 + CSW'(cell3[d]);
    end
  end

  // control that rides with each item; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 6; s++) begin
        ctl_r[s].vld <= 1'b0;
      end
    end else if (en) begin
      ctl_r[1].vld  <= in_valid;
      ctl_r[1].ld   <= in_opcode;
      ctl_r[1].pidx <= in_perm_index;
      ctl_r[1].pval <= in_perm_value;
      for (int s = 2; s <= 6; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture and add coordinates
      sum1_r <= 26'(in_coord_x) + 26'(in_coord_y) + 26'(in_coord_z) + 26'(in_coord_w);
      for (int d = 0; d < 4; d++) begin
        c1_r[d] <= cin[d];
      end

      // stage 2: skew multiply
      prod2_r <= MW'(sum1_r) * MW'(sn4_pkg::F4_Q32);
      for (int d = 0; d < 4; d++) begin
        c2_r[d] <= c1_r[d];
      end

      // stage 3: coordinate plus skew
      skew3_r <= skew2;
      for (int d = 0; d < 4; d++) begin
        ps3_r[d] <= SW'($signed({c2_r[d], {(WB - FRAC_BITS){1'b0}}})) + skew2;
      end

      // stage 4: split cell and fraction
      csum4_r <= csum3;
      skew4_r <= skew3_r;
      for (int d = 0; d < 4; d++) begin
        frac4_r[d] <= ps3_r[d][WB-1:0];
        cb4_r[d]   <= cellx3[d][7:0];
      end

      // stage 5: unskew multiply
      unsk5_r <= UW'(csum4_r) * UW'($signed({1'b0, sn4_pkg::G4_Q28}));
      skew5_r <= skew4_r;
      for (int d = 0; d < 4; d++) begin
        frac5_r[d] <= frac4_r[d];
        cb5_r[d]   <= cb4_r[d];
      end

      // stage 6: offset from the cell origin
      for (int d = 0; d < 4; d++) begin
        off6_r[d] <= 32'(XW'($signed({1'b0, frac5_r[d]})) + XW'(unsk5_r) - XW'(skew5_r));
        cb6_r[d]  <= cb5_r[d];
      end
    end
  end

  assign front_o.ctl = ctl_r[6];
  assign front_o.cb  = cb6_r;
  assign front_o.off = off6_r;

endmodule

>>> hw/rtl/sn4_corner.sv
// One simplex corner: distance, falloff to the fourth power, gradient dot, contribution.
`timescale 1ns / 1ps

module sn4_corner (
  input  logic               clk,
  input  logic               en,
  input  logic [3:0][31:0]   off_i,
  input  logic [3:0]         step_i,
  input  logic [27:0]        kofs_i,
  input  logic [4:0]         grad_i,
  output logic signed [34:0] contrib_o
);

  localparam int WB = sn4_pkg::WORK_BITS;

  logic signed [31:0] v8_r   [4];
  logic signed [31:0] v9_r   [4];
  logic [63:0]        sq9_r  [4];
  logic signed [31:0] v10_r  [4];
  logic [27:0]        f10_r;
  logic               act10_r;
  logic signed [31:0] v11_r  [4];
  logic [27:0]        f2_11_r;
  logic               act11_r;
  logic [27:0]        f4_12_r;
  logic signed [33:0] dot12_r;
  logic               act12_r;
  logic signed [34:0] ct13_r;

  logic [63:0]        r2;
  logic signed [37:0] fall;
  logic [55:0]        f2sq;
  logic [55:0]        f4sq;
  logic signed [33:0] dot;
  logic signed [33:0] term;
  logic [1:0]         zpos;
  logic [1:0]         spos;
  logic signed [62:0] cprod;

  // squared distance and falloff 0.6 - r^2
  always_comb begin
    r2 = '0;
    for (int d = 0; d < 4; d++) begin
      r2 = r2 + sq9_r[d];
    end
    fall = $signed({10'b0, sn4_pkg::FALLOFF_Q28}) - $signed({2'b0, r2[63:WB]});
  end

  // gradient: zero axis from the top two bits, signs of the other three below
  always_comb begin
    zpos = grad_i[4:3];
    dot  = '0;
    for (int d = 0; d < 4; d++) begin
      term = 34'(v11_r[d]);
      spos = (2'(d) < zpos) ? 2'(d) : 2'(d - 1);
      if (2'(d) != zpos) begin
        if (grad_i[2 - spos]) begin
          dot = dot - term;
        end else begin
          dot = dot + term;
        end
      end
    end
  end

  assign f2sq  = f10_r * f10_r;
  assign f4sq  = f2_11_r * f2_11_r;
  assign cprod = 63'($signed({1'b0, f4_12_r})) * 63'(dot12_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // offset of this corner
      for (int d = 0; d < 4; d++) begin
        v8_r[d] <= $signed(off_i[d]) - (step_i[d] ? 32'sh1000_0000 : 32'sh0)
                   + $signed({4'b0, kofs_i});
      end
      // squares
      for (int d = 0; d < 4; d++) begin
        v9_r[d]  <= v8_r[d];
        sq9_r[d] <= 64'(v8_r[d] * v8_r[d]);
      end
      // falloff, clipped to zero when outside the radius
      act10_r <= !fall[37];
      f10_r   <= fall[37] ? 28'd0 : fall[27:0];
      for (int d = 0; d < 4; d++) begin
        v10_r[d] <= v9_r[d];
      end
      // falloff squared
      f2_11_r <= f2sq[55:WB];
      act11_r <= act10_r;
      for (int d = 0; d < 4; d++) begin
        v11_r[d] <= v10_r[d];
      end
      // falloff to the fourth, gradient dot
      f4_12_r <= f4sq[55:WB];
      dot12_r <= dot;
      act12_r <= act11_r;
      // weighted contribution
      ct13_r <= act12_r ? 35'(cprod >>> WB) : 35'sd0;
    end
  end

  assign contrib_o = ct13_r;

endmodule
